// ===== hw/rtl/eye_track_calibrate_smooth_macros.svh =====
// Assertion macros shared by the eye-tracker calibrate/smooth RTL
`ifndef EYE_TRACK_CALIBRATE_SMOOTH_MACROS_SVH
`define EYE_TRACK_CALIBRATE_SMOOTH_MACROS_SVH

// same-cycle implication, disabled during reset
`define ETCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ETCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/etcs_pkg.sv =====
// Types, constants and helper functions for the eye-tracker calibrate/smooth block
package etcs_pkg;

  localparam int NCH = 7;
  localparam int QW  = 24;

  // lane order
  localparam int LANE_CX = 0;
  localparam int LANE_CY = 1;
  localparam int LANE_CZ = 2;
  localparam int LANE_LX = 3;
  localparam int LANE_LY = 4;
  localparam int LANE_RX = 5;
  localparam int LANE_RY = 6;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic [26:0] DIV5_BIAS = 27'd83886080;   // 5 * 2^24
  localparam logic [26:0] DIV5_MUL  = 27'd107374183;  // ceil(2^29 / 5)
  localparam logic [24:0] DIV5_OFS  = 25'd16777216;   // bias / 5

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_RECAL    = 3'd1,
    ST_NOTRACK  = 3'd2,
    ST_STALE    = 3'd3,
    ST_BAD      = 3'd4,
    ST_UPDATED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_ALPHA      = 3'd1,
    REG_HORIZONTAL = 3'd2,
    REG_VERTICAL   = 3'd3,
    REG_DEPTH      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        enable;
    logic [16:0] alpha;
    logic        h_en;
    logic        v_en;
    logic        d_en;
  } cfg_t;

  // value * mul split as 5*q + r, r in 0..4
  typedef struct packed {
    logic signed [QW-1:0] q;
    logic [2:0]           r;
  } lane_t;

  typedef struct packed {
    logic                     recalibrate;
    logic                     tracker_active;
    logic [31:0]              frame_number;
    logic                     sample_finite;
    lane_t [NCH-1:0]          lane;
  } pre_t;

  // floor division by 5 of a value in [-2^24, 2^24)
  function automatic lane_t div5(input logic signed [25:0] x);
    logic [26:0] u;
    logic [53:0] prod;
    logic [24:0] qu;
    logic [26:0] five_q;
    lane_t       res;
    u      = 27'(x) + DIV5_BIAS;
    prod   = u * DIV5_MUL;
    qu     = prod[53:29];
    five_q = {2'b00, qu} + {qu, 2'b00};
    res.q  = QW'($signed(qu - DIV5_OFS));
    res.r  = 3'(u - five_q);
    return res;
  endfunction

  // rounded half up from 1/16384 cm to 1/256 cm
  function automatic logic signed [17:0] round_out(input logic signed [QW-1:0] s);
    logic signed [QW:0] t;
    t = (QW+1)'(s) + (QW+1)'(32);
    return $signed(t[23:6]);
  endfunction

endpackage

// ===== hw/rtl/etcs_if.sv =====
// Sample and result channel interfaces
interface etcs_in_if;
  logic               valid;
  logic               ready;
  logic               recalibrate;
  logic               tracker_active;
  logic [31:0]        frame_number;
  logic               sample_finite;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] left_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;

  modport source (output valid, recalibrate, tracker_active, frame_number, sample_finite,
                  left_x, left_y, left_z, right_x, right_y, right_z, input ready);
  modport sink (input valid, recalibrate, tracker_active, frame_number, sample_finite,
                left_x, left_y, left_z, right_x, right_y, right_z, output ready);
endinterface

interface etcs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               tracking;
  logic [31:0]        frame_out;
  logic signed [17:0] head_horizontal;
  logic signed [17:0] head_vertical;
  logic signed [17:0] head_depth;
  logic signed [17:0] left_horizontal;
  logic signed [17:0] left_vertical;
  logic signed [17:0] right_horizontal;
  logic signed [17:0] right_vertical;

  modport source (output valid, status, tracking, frame_out, head_horizontal, head_vertical,
                  head_depth, left_horizontal, left_vertical, right_horizontal,
                  right_vertical, input ready);
  modport sink (input valid, status, tracking, frame_out, head_horizontal, head_vertical,
                head_depth, left_horizontal, left_vertical, right_horizontal,
                right_vertical, output ready);
endinterface

// ===== hw/rtl/eye_track_calibrate_smooth.sv =====
// Top level of the eye-tracker calibrate and smooth block
// Takes one sample transfer per clock while the result side is not stalled, and returns exactly
// one result transfer per sample, registered in the input stage and then the output register.
// The first register stage scales the coordinates and splits them by five; the second holds
// the calibration reference and the seven EMA lanes, each updated by one 18x25 multiply, so
// consecutive samples follow each other without gaps. A stalled result holds in the output
// register while one further sample waits in the input stage. Configuration takes effect on
// the next sample and should be written only while no sample is in flight.
module eye_track_calibrate_smooth
  import etcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  etcs_in_if.sink     sample_ch,
  etcs_out_if.source  result_ch
);

  cfg_t cfg;
  logic pre_vld;
  pre_t pre;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.alpha  <= 17'd19661;
      cfg.h_en   <= 1'b1;
      cfg.v_en   <= 1'b1;
      cfg.d_en   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     cfg.enable <= cfg_wdata[0];
        REG_ALPHA:      cfg.alpha  <= cfg_wdata;
        REG_HORIZONTAL: cfg.h_en   <= cfg_wdata[0];
        REG_VERTICAL:   cfg.v_en   <= cfg_wdata[0];
        REG_DEPTH:      cfg.d_en   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  etcs_prescale u_prescale (
    .clk  (clk),
    .rst  (rst),
    .smp  (sample_ch),
    .take (take),
    .vld  (pre_vld),
    .pre  (pre)
  );

  etcs_update u_update (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pre_vld (pre_vld),
    .pre     (pre),
    .take    (take),
    .res     (result_ch)
  );

endmodule

// ===== hw/rtl/etcs_prescale.sv =====
// Input register: scales sample coordinates to 1/16384 cm and splits them by five
module etcs_prescale
  import etcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  etcs_in_if.sink    smp,
  input  logic       take,
  output logic       vld,
  output pre_t       pre
);

  logic signed [16:0] cs_x, cs_y, cs_z;
  logic signed [25:0] scaled [NCH];
  pre_t               pre_next;

  assign smp.ready = !vld || take;

  assign cs_x = {smp.left_x[15], smp.left_x} + {smp.right_x[15], smp.right_x};
  assign cs_y = {smp.left_y[15], smp.left_y} + {smp.right_y[15], smp.right_y};
  assign cs_z = {smp.left_z[15], smp.left_z} + {smp.right_z[15], smp.right_z};

  // centre sums are 1/32 mm (x256), eyes 1/16 mm (x512)
  assign scaled[LANE_CX] = $signed({cs_x[16], cs_x, 8'h00});
  assign scaled[LANE_CY] = $signed({cs_y[16], cs_y, 8'h00});
  assign scaled[LANE_CZ] = $signed({cs_z[16], cs_z, 8'h00});
  assign scaled[LANE_LX] = $signed({smp.left_x[15], smp.left_x, 9'h000});
  assign scaled[LANE_LY] = $signed({smp.left_y[15], smp.left_y, 9'h000});
  assign scaled[LANE_RX] = $signed({smp.right_x[15], smp.right_x, 9'h000});
  assign scaled[LANE_RY] = $signed({smp.right_y[15], smp.right_y, 9'h000});

  always_comb begin
    pre_next.recalibrate    = smp.recalibrate;
    pre_next.tracker_active = smp.tracker_active;
    pre_next.frame_number   = smp.frame_number;
    pre_next.sample_finite  = smp.sample_finite;
    for (int i = 0; i < NCH; i++) begin
      pre_next.lane[i] = div5(scaled[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (smp.ready) begin
      vld <= smp.valid;
    end
    if (smp.valid && smp.ready) begin
      pre <= pre_next;
    end
  end

endmodule

// ===== hw/rtl/etcs_update.sv =====
// Calibration state, seven-lane EMA update and result register
`include "eye_track_calibrate_smooth_macros.svh"

module etcs_update
  import etcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       pre_vld,
  input  pre_t       pre,
  output logic       take,
  etcs_out_if.source res
);

  // state
  logic                  calibrated;
  logic [31:0]           last_frame;
  logic                  tracking_flag;
  logic [31:0]           pub_frame;
  logic [NCH-1:0][QW-1:0] smooth;
  logic signed [QW-1:0]  ref_q [NCH];
  logic [2:0]            ref_r [NCH];

  // result register
  logic                  o_valid;
  status_t               o_status;
  logic                  o_tracking;
  logic [31:0]           o_frame;
  logic [NCH-1:0][QW-1:0] o_smooth;

  logic                  calibrated_next;
  logic [31:0]           last_frame_next;
  logic                  tracking_next;
  logic [31:0]           pub_frame_next;
  logic [NCH-1:0][QW-1:0] smooth_next;
  logic [NCH-1:0][QW-1:0] smooth_new;
  status_t               status_next;
  logic                  do_calib;
  logic [16:0]           alpha_eff;
  logic [NCH-1:0]        pass;

  assign take      = pre_vld && (!o_valid || res.ready);
  assign alpha_eff = cfg.alpha[16] ? ALPHA_ONE : cfg.alpha;
  assign pass      = {cfg.v_en, cfg.h_en, cfg.v_en, cfg.h_en, cfg.d_en, cfg.v_en, cfg.h_en};

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    lane_t              ln;
    logic signed [24:0] dq;
    logic signed [3:0]  dr;
    logic signed [24:0] tgt_raw;
    logic signed [24:0] tgt_dir;
    logic signed [QW-1:0] tgt;
    logic signed [QW-1:0] s_cur;
    logic signed [24:0] delta;
    logic signed [42:0] prod;
    logic signed [42:0] acc;

    assign ln      = pre.lane[g];
    assign s_cur   = $signed(smooth[g]);
    assign dq      = 25'(ln.q) - 25'(ref_q[g]);
    assign dr      = $signed({1'b0, ln.r}) - $signed({1'b0, ref_r[g]});
    // round to nearest on the remainder difference
    assign tgt_raw = dq + ((dr >= 4'sd3) ? 25'sd1 : ((dr <= -4'sd3) ? -25'sd1 : 25'sd0));
    assign tgt_dir = (g == LANE_CZ) ? -tgt_raw : tgt_raw;
    assign tgt     = (calibrated && pass[g]) ? QW'(tgt_dir) : '0;
    assign delta   = 25'(tgt) - 25'(s_cur);
    assign prod    = $signed({1'b0, alpha_eff}) * delta;
    assign acc     = prod + 43'($signed({s_cur, 16'h8000}));
    assign smooth_new[g] = acc[39:16];
  end

  always_comb begin
    calibrated_next = calibrated;
    last_frame_next = last_frame;
    tracking_next   = tracking_flag;
    pub_frame_next  = pub_frame;
    smooth_next     = smooth;
    do_calib        = 1'b0;
    status_next     = ST_DISABLED;
    if (pre.recalibrate) begin
      calibrated_next = 1'b0;
      last_frame_next = '0;
      tracking_next   = 1'b0;
      pub_frame_next  = '0;
      smooth_next     = '0;
      status_next     = ST_RECAL;
    end else if (!cfg.enable) begin
      status_next = ST_DISABLED;
    end else if (!pre.tracker_active || pre.frame_number == '0) begin
      tracking_next = 1'b0;
      status_next   = ST_NOTRACK;
    end else if (pre.frame_number == last_frame) begin
      status_next = ST_STALE;
    end else begin
      last_frame_next = pre.frame_number;
      if (!pre.sample_finite) begin
        status_next = ST_BAD;
      end else begin
        do_calib        = !calibrated;
        calibrated_next = 1'b1;
        smooth_next     = smooth_new;
        tracking_next   = 1'b1;
        pub_frame_next  = pre.frame_number;
        status_next     = ST_UPDATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated    <= 1'b0;
      last_frame    <= '0;
      tracking_flag <= 1'b0;
      pub_frame     <= '0;
      smooth        <= '0;
      o_valid       <= 1'b0;
    end else begin
      if (take) begin
        calibrated    <= calibrated_next;
        last_frame    <= last_frame_next;
        tracking_flag <= tracking_next;
        pub_frame     <= pub_frame_next;
        smooth        <= smooth_next;
        o_valid       <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (take) begin
      o_status   <= status_next;
      o_tracking <= tracking_next;
      o_frame    <= pub_frame_next;
      o_smooth   <= smooth_next;
    end
    if (take && do_calib) begin
      for (int i = 0; i < NCH; i++) begin
        ref_q[i] <= pre.lane[i].q;
        ref_r[i] <= pre.lane[i].r;
      end
    end
  end

  assign res.valid            = o_valid;
  assign res.status           = o_status;
  assign res.tracking         = o_tracking;
  assign res.frame_out        = o_frame;
  assign res.head_horizontal  = round_out($signed(o_smooth[LANE_CX]));
  assign res.head_vertical    = round_out($signed(o_smooth[LANE_CY]));
  assign res.head_depth       = round_out($signed(o_smooth[LANE_CZ]));
  assign res.left_horizontal  = round_out($signed(o_smooth[LANE_LX]));
  assign res.left_vertical    = round_out($signed(o_smooth[LANE_LY]));
  assign res.right_horizontal = round_out($signed(o_smooth[LANE_RX]));
  assign res.right_vertical   = round_out($signed(o_smooth[LANE_RY]));

  `ETCS_ASSERT_NOW(a_uncal_zero, !calibrated, smooth == '0, "smoothed state nonzero while uncalibrated")
  `ETCS_ASSERT_NOW(a_cal_frame, calibrated, last_frame != '0, "calibrated with no frame seen")
  `ETCS_ASSERT_NEXT(a_recal_clear, take && pre.recalibrate, !calibrated && smooth == '0 && last_frame == '0 && !o_tracking, "recalibrate did not clear state")
  `ETCS_ASSERT_NOW(a_upd_track, o_valid && o_status == ST_UPDATED, o_tracking && o_frame != '0, "updated result without tracking")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for eye_track_calibrate_smooth: directed and random samples against a local predictor
`timescale 1ns / 100ps

module tb_top;
  import etcs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic               recal;
    logic               active;
    logic [31:0]        frame;
    logic               finite;
    logic signed [15:0] lx, ly, lz, rx, ry, rz;
  } sample_t;

  typedef struct {
    status_t            status;
    logic               tracking;
    logic [31:0]        frame;
    logic signed [17:0] lanes [7];
  } result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_wdata;

  etcs_in_if  sample_ch();
  etcs_out_if result_ch();

  eye_track_calibrate_smooth dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // register copies
  logic        cfg_en;
  logic [16:0] cfg_alpha;
  logic        cfg_h, cfg_v, cfg_d;

  // tracking state
  logic        calibrated;
  logic [31:0] seen_frame;
  logic        track_flag;
  logic [31:0] shown_frame;
  int          centre_zero [3];
  int          eye_zero [4];
  int          ema [7];

  result_t     pending_results [$];
  int          mismatches = 0;
  int          src_idle = 0;
  int          sink_stall = 0;
  int unsigned frame_seq = 0;
  int unsigned cycle_count = 0;

  string lane_name [7] = '{"head_horizontal", "head_vertical", "head_depth",
                           "left_horizontal", "left_vertical", "right_horizontal",
                           "right_vertical"};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_stall);
  end

  function automatic void clear_tracking();
    calibrated  = 1'b0;
    seen_frame  = '0;
    track_flag  = 1'b0;
    shown_frame = '0;
    for (int i = 0; i < 3; i++) centre_zero[i] = 0;
    for (int i = 0; i < 4; i++) eye_zero[i] = 0;
    for (int i = 0; i < 7; i++) ema[i] = 0;
  endfunction

  // round(n * mul / 5) to nearest
  function automatic longint cm_target(input longint n, input longint mul);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m * mul * 2 + 5) / 10;
    return (n < 0) ? -q : q;
  endfunction

  function automatic result_t smooth_step(input sample_t s);
    result_t r;
    longint  t [7];
    longint  a, acc;
    int      cs [3];
    if (s.recal) begin
      clear_tracking();
      r.status = ST_RECAL;
    end else if (!cfg_en) begin
      r.status = ST_DISABLED;
    end else if (!s.active || s.frame == 0) begin
      track_flag = 1'b0;
      r.status = ST_NOTRACK;
    end else if (s.frame == seen_frame) begin
      r.status = ST_STALE;
    end else begin
      seen_frame = s.frame;
      if (!s.finite) begin
        r.status = ST_BAD;
      end else begin
        cs[0] = int'(s.lx) + int'(s.rx);
        cs[1] = int'(s.ly) + int'(s.ry);
        cs[2] = int'(s.lz) + int'(s.rz);
        if (!calibrated) begin
          for (int i = 0; i < 3; i++) centre_zero[i] = cs[i];
          eye_zero[0] = s.lx;
          eye_zero[1] = s.ly;
          eye_zero[2] = s.rx;
          eye_zero[3] = s.ry;
          calibrated = 1'b1;
        end
        t[0] = cm_target(longint'(cs[0]) - centre_zero[0], 256);
        t[1] = cm_target(longint'(cs[1]) - centre_zero[1], 256);
        t[2] = -cm_target(longint'(cs[2]) - centre_zero[2], 256);
        t[3] = cm_target(longint'(s.lx) - eye_zero[0], 512);
        t[4] = cm_target(longint'(s.ly) - eye_zero[1], 512);
        t[5] = cm_target(longint'(s.rx) - eye_zero[2], 512);
        t[6] = cm_target(longint'(s.ry) - eye_zero[3], 512);
        if (!cfg_h) begin
          t[0] = 0;
          t[3] = 0;
          t[5] = 0;
        end
        if (!cfg_v) begin
          t[1] = 0;
          t[4] = 0;
          t[6] = 0;
        end
        if (!cfg_d) t[2] = 0;
        a = (cfg_alpha > 17'd65536) ? 65536 : longint'(cfg_alpha);
        for (int i = 0; i < 7; i++) begin
          acc = a * t[i] + (65536 - a) * longint'(ema[i]) + 32768;
          ema[i] = int'(acc >>> 16);
        end
        track_flag  = 1'b1;
        shown_frame = s.frame;
        r.status = ST_UPDATED;
      end
    end
    r.tracking = track_flag;
    r.frame    = shown_frame;
    for (int i = 0; i < 7; i++) r.lanes[i] = 18'((ema[i] + 32) >>> 6);
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    result_t            want;
    logic signed [17:0] got [7];
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        got[0] = result_ch.head_horizontal;
        got[1] = result_ch.head_vertical;
        got[2] = result_ch.head_depth;
        got[3] = result_ch.left_horizontal;
        got[4] = result_ch.left_vertical;
        got[5] = result_ch.right_horizontal;
        got[6] = result_ch.right_vertical;
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_ch.status);
          mismatches++;
        end
        if (result_ch.tracking !== want.tracking) begin
          $error("tracking: expected %0d, got %0d", want.tracking, result_ch.tracking);
          mismatches++;
        end
        if (result_ch.frame_out !== want.frame) begin
          $error("frame_out: expected %0d, got %0d", want.frame, result_ch.frame_out);
          mismatches++;
        end
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want.lanes[i]) begin
            $error("%s: expected %0d, got %0d", lane_name[i], want.lanes[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.recalibrate    <= s.recal;
    sample_ch.tracker_active <= s.active;
    sample_ch.frame_number   <= s.frame;
    sample_ch.sample_finite  <= s.finite;
    sample_ch.left_x         <= s.lx;
    sample_ch.left_y         <= s.ly;
    sample_ch.left_z         <= s.lz;
    sample_ch.right_x        <= s.rx;
    sample_ch.right_y        <= s.ry;
    sample_ch.right_z        <= s.rz;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_results.push_back(smooth_step(s));
  endtask

  // stop sending and let every expected transfer arrive
  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_reg_t idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ENABLE:     cfg_en = val[0];
      REG_ALPHA:      cfg_alpha = val;
      REG_HORIZONTAL: cfg_h = val[0];
      REG_VERTICAL:   cfg_v = val[0];
      REG_DEPTH:      cfg_d = val[0];
      default: ;
    endcase
  endtask

  function automatic sample_t mk_sample(input logic recal, input logic active,
                                        input logic [31:0] frame, input logic finite,
                                        input int lx, input int ly, input int lz,
                                        input int rx, input int ry, input int rz);
    sample_t s;
    s.recal  = recal;
    s.active = active;
    s.frame  = frame;
    s.finite = finite;
    s.lx = 16'(lx);
    s.ly = 16'(ly);
    s.lz = 16'(lz);
    s.rx = 16'(rx);
    s.ry = 16'(ry);
    s.rz = 16'(rz);
    return s;
  endfunction

  function automatic logic signed [15:0] rand_coord(input int centre);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(centre + int'($urandom_range(2047)) - 1024);
  endfunction

  function automatic logic [31:0] fresh_frame();
    if ($urandom_range(19) == 0) frame_seq = $urandom;
    else frame_seq = frame_seq + $urandom_range(1, 5);
    if (frame_seq == 0) frame_seq = 1;
    return frame_seq;
  endfunction

  // mostly clean tracked frames, with recalibrations, dropouts, repeats and bad samples
  function automatic sample_t rand_sample();
    sample_t s;
    int      pick;
    pick = $urandom_range(99);
    s.recal  = (pick < 3);
    s.active = !(pick >= 3 && pick < 7) || ($urandom_range(7) == 0 && pick >= 7);
    s.finite = !(pick >= 14 && pick < 19);
    if (pick < 7) s.frame = $urandom;
    else if (pick < 9) s.frame = '0;
    else if (pick < 14) s.frame = seen_frame;
    else s.frame = fresh_frame();
    if (pick >= 3 && pick < 7) s.active = 1'b0;
    s.lx = rand_coord(-512);
    s.ly = rand_coord(0);
    s.lz = rand_coord(9600);
    s.rx = rand_coord(512);
    s.ry = rand_coord(0);
    s.rz = rand_coord(9600);
    return s;
  endfunction

  task automatic pick_settings();
    logic [16:0] alphas [6] = '{17'd0, 17'd1, 17'd19661, 17'd65535, 17'd65536, 17'd131071};
    if ($urandom_range(2) == 0) reg_write(REG_ALPHA, alphas[$urandom_range(5)]);
    else reg_write(REG_ALPHA, 17'($urandom_range(1, 65536)));
    reg_write(REG_HORIZONTAL, 17'($urandom_range(3) != 0));
    reg_write(REG_VERTICAL, 17'($urandom_range(3) != 0));
    reg_write(REG_DEPTH, 17'($urandom_range(3) != 0));
  endtask

  task automatic run_phase(input int n, input int src, input int snk);
    src_idle   = src;
    sink_stall = snk;
    repeat (n) send_sample(rand_sample());
  endtask

  task automatic test_disabled();
    src_idle   = 0;
    sink_stall = 30;
    send_sample(mk_sample(1'b0, 1'b1, 32'd7, 1'b1, -400, 20, 9000, 400, 20, 9000));
    send_sample(mk_sample(1'b1, 1'b1, 32'd8, 1'b1, 100, 100, 100, 100, 100, 100));
  endtask

  task automatic test_calibration();
    wait_idle();
    reg_write(REG_ENABLE, 17'd1);
    reg_write(REG_ALPHA, 17'd65536);
    src_idle   = 30;
    sink_stall = 30;
    send_sample(mk_sample(1'b0, 1'b1, 32'd1, 1'b1, 0, 0, 0, 0, 0, 0));
    send_sample(mk_sample(1'b0, 1'b1, 32'd2, 1'b1, 32767, -32768, 32767,
                          32767, -32768, 32767));
    send_sample(mk_sample(1'b0, 1'b1, 32'd3, 1'b1, -32768, 32767, -32768,
                          -32768, 32767, -32768));
    send_sample(mk_sample(1'b0, 1'b1, 32'd3, 1'b1, 5, 5, 5, 5, 5, 5));
    send_sample(mk_sample(1'b0, 1'b1, 32'd0, 1'b1, 5, 5, 5, 5, 5, 5));
    send_sample(mk_sample(1'b0, 1'b0, 32'd4, 1'b1, 5, 5, 5, 5, 5, 5));
    send_sample(mk_sample(1'b0, 1'b1, 32'd4, 1'b0, 9, 9, 9, 9, 9, 9));
    send_sample(mk_sample(1'b0, 1'b1, 32'd4, 1'b1, 9, 9, 9, 9, 9, 9));
    send_sample(mk_sample(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, -300, 150, 8000,
                          300, 150, 8100));
    send_sample(mk_sample(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, -1, -1, -1, -1, -1, -1));
    send_sample(mk_sample(1'b0, 1'b1, 32'd5, 1'b1, 32767, 32767, 32767,
                          32767, 32767, 32767));
    send_sample(mk_sample(1'b0, 1'b1, 32'd6, 1'b1, -32768, -32768, -32768,
                          -32768, -32768, -32768));
  endtask

  task automatic test_alpha_limits();
    wait_idle();
    reg_write(REG_ALPHA, 17'd131071);
    send_sample(mk_sample(1'b0, 1'b1, 32'd10, 1'b1, 1000, -2000, 3000, -4000, 5000, -6000));
    wait_idle();
    reg_write(REG_ALPHA, 17'd65537);
    send_sample(mk_sample(1'b0, 1'b1, 32'd11, 1'b1, -700, 800, -900, 700, -800, 900));
    wait_idle();
    reg_write(REG_ALPHA, 17'd0);
    send_sample(mk_sample(1'b0, 1'b1, 32'd12, 1'b1, 32767, 32767, 0, 0, 0, 0));
    send_sample(mk_sample(1'b0, 1'b1, 32'd13, 1'b1, 0, 0, 0, -32768, -32768, 0));
    wait_idle();
    reg_write(REG_ALPHA, 17'd1);
    send_sample(mk_sample(1'b0, 1'b1, 32'd14, 1'b1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_axis_enables();
    wait_idle();
    reg_write(REG_ALPHA, 17'd19661);
    reg_write(REG_HORIZONTAL, 17'd0);
    send_sample(mk_sample(1'b0, 1'b1, 32'd20, 1'b1, 2000, 2000, 2000, 2000, 2000, 2000));
    wait_idle();
    reg_write(REG_VERTICAL, 17'd0);
    send_sample(mk_sample(1'b0, 1'b1, 32'd21, 1'b1, -2000, -2000, -2000, -2000, -2000, -2000));
    wait_idle();
    reg_write(REG_DEPTH, 17'd0);
    send_sample(mk_sample(1'b0, 1'b1, 32'd22, 1'b1, 3000, 3000, 3000, 3000, 3000, 3000));
    wait_idle();
    reg_write(REG_HORIZONTAL, 17'd1);
    reg_write(REG_VERTICAL, 17'd1);
    reg_write(REG_DEPTH, 17'd1);
    send_sample(mk_sample(1'b0, 1'b1, 32'd23, 1'b1, 100, -100, 200, -200, 300, -300));
  endtask

  task automatic test_random();
    frame_seq = 100;
    wait_idle();
    reg_write(REG_ALPHA, 17'd19661);
    run_phase(250, 0, 0);
    wait_idle();
    pick_settings();
    run_phase(125, 58, 0);
    // hold off until the result side has caught up, then carry on
    wait_idle();
    run_phase(125, 58, 0);
    wait_idle();
    pick_settings();
    reg_write(REG_ALPHA, 17'd65536);
    run_phase(250, 0, 58);
    wait_idle();
    pick_settings();
    run_phase(250, 30, 30);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_wdata = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.recalibrate    = 1'b0;
    sample_ch.tracker_active = 1'b0;
    sample_ch.frame_number   = '0;
    sample_ch.sample_finite  = 1'b0;
    sample_ch.left_x         = '0;
    sample_ch.left_y         = '0;
    sample_ch.left_z         = '0;
    sample_ch.right_x        = '0;
    sample_ch.right_y        = '0;
    sample_ch.right_z        = '0;
    result_ch.ready          = 1'b0;
    cfg_en    = 1'b0;
    cfg_alpha = 17'd19661;
    cfg_h     = 1'b1;
    cfg_v     = 1'b1;
    cfg_d     = 1'b1;
    clear_tracking();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled();
    test_calibration();
    test_alpha_limits();
    test_axis_enables();
    test_random();

    wait_idle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
